// ===== design/tqda_pkg.sv =====
// Shared constants and helpers for the face double-area pipeline.
`timescale 1ns / 1ps

package tqda_pkg;

	// Number of coordinate axes of one corner.
	localparam int AXES = 3;

	// Width of the double_area result and of the padded output stream word.
	localparam int OUT_BITS = 36;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Face mode register codes.
	localparam logic [1:0] MODE_2D = 2'd0;
	localparam logic [1:0] MODE_TRI = 2'd1;
	localparam logic [1:0] MODE_QUAD = 2'd2;
	// Any code with this bit set selects the quad path.
	localparam logic [1:0] QUAD_FLAG = 2'b10;

	// Axis that pairs with axis k in the projected cross products: x-y, y-z, z-x.
	function automatic int next_axis(input int k);
		int n;
		n = (k == AXES - 1) ? 0 : k + 1;
		return n;
	endfunction

endpackage

// ===== design/tqda_cross.sv =====
// Edge vectors, projected cross products and their magnitudes for one triangle.
`timescale 1ns / 1ps

module tqda_cross #(
	parameter int COORD_BITS = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [COORD_BITS-1:0]   p [tqda_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]   q [tqda_pkg::AXES],
	input  logic signed [COORD_BITS-1:0]   t [tqda_pkg::AXES],
	output logic        [2*COORD_BITS+1:0] mag [tqda_pkg::AXES],
	output logic signed [2*COORD_BITS+2:0] cross_xy
);

	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * COORD_BITS + 2;
	localparam int CROSS_W = 2 * COORD_BITS + 3;
	localparam int MAG_W = 2 * COORD_BITS + 2;

	logic signed [DIFF_W-1:0]  r_s1 [tqda_pkg::AXES];
	logic signed [DIFF_W-1:0]  s_s1 [tqda_pkg::AXES];
	logic signed [PROD_W-1:0]  pa_s2 [tqda_pkg::AXES];
	logic signed [PROD_W-1:0]  pb_s2 [tqda_pkg::AXES];
	logic signed [CROSS_W-1:0] cr_s3 [tqda_pkg::AXES];
	logic        [MAG_W-1:0]   mag_s4 [tqda_pkg::AXES];
	logic signed [CROSS_W-1:0] xy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < tqda_pkg::AXES; k++) begin
				r_s1[k] <= DIFF_W'(p[k]) - DIFF_W'(t[k]);
				s_s1[k] <= DIFF_W'(q[k]) - DIFF_W'(t[k]);
				pa_s2[k] <= r_s1[k] * s_s1[tqda_pkg::next_axis(k)];
				pb_s2[k] <= r_s1[tqda_pkg::next_axis(k)] * s_s1[k];
				cr_s3[k] <= CROSS_W'(pa_s2[k]) - CROSS_W'(pb_s2[k]);
				// The magnitude never exceeds 2^(2*COORD_BITS+1), so MAG_W bits hold it.
				mag_s4[k] <= cr_s3[k][CROSS_W-1] ? MAG_W'(-cr_s3[k]) : MAG_W'(cr_s3[k]);
			end
			xy_s4 <= cr_s3[0];
		end
	end

	assign mag = mag_s4;
	assign cross_xy = xy_s4;

endmodule

// ===== design/tqda_square.sv =====
// Squares the three cross product magnitudes from half-width products and sums them.
`timescale 1ns / 1ps

module tqda_square #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [2*COORD_BITS+1:0] mag [tqda_pkg::AXES],
	output logic [4*COORD_BITS+5:0] sum
);

	localparam int MAG_W = 2 * COORD_BITS + 2;
	localparam int LO_W = (MAG_W + 1) / 2;
	localparam int HI_W = MAG_W - LO_W;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;

	logic [2*HI_W-1:0] hh_s5 [tqda_pkg::AXES];
	logic [MAG_W-1:0]  hl_s5 [tqda_pkg::AXES];
	logic [2*LO_W-1:0] ll_s5 [tqda_pkg::AXES];
	logic [SQ_W-1:0]   sq_s6 [tqda_pkg::AXES];
	logic [SUM_W-1:0]  sum_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < tqda_pkg::AXES; k++) begin
				hh_s5[k] <= mag[k][MAG_W-1:LO_W] * mag[k][MAG_W-1:LO_W];
				hl_s5[k] <= mag[k][MAG_W-1:LO_W] * mag[k][LO_W-1:0];
				ll_s5[k] <= mag[k][LO_W-1:0] * mag[k][LO_W-1:0];
				// m^2 = hi^2 * 2^(2L) + 2 * hi * lo * 2^L + lo^2
				sq_s6[k] <= (SQ_W'(hh_s5[k]) << (2 * LO_W))
					+ (SQ_W'(hl_s5[k]) << (LO_W + 1))
					+ SQ_W'(ll_s5[k]);
			end
			sum_s7 <= SUM_W'(sq_s6[0]) + SUM_W'(sq_s6[1]) + SUM_W'(sq_s6[2]);
		end
	end

	assign sum = sum_s7;

endmodule

// ===== design/tqda_isqrt.sv =====
// Floor integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps

module tqda_isqrt #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [4*COORD_BITS+5:0] rad,
	output logic [2*COORD_BITS+2:0] root
);

	localparam int ROOT_W = 2 * COORD_BITS + 3;
	localparam int RAD_W = 2 * ROOT_W;

	// Stage i settles result bit ROOT_W-1-i; rem_s holds rad minus the root squared so far.
	logic [RAD_W-1:0]  rem_s [ROOT_W-1];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
		localparam int B = ROOT_W - 1 - i;
		logic [RAD_W-1:0]  rem_in;
		logic [RAD_W-1:0]  trial;
		logic [ROOT_W-1:0] root_in;
		logic              take;

		if (i == 0) begin : g_first
			assign rem_in = rad;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign root_in = root_s[i-1];
		end

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B); the two terms do not overlap.
		assign trial = (RAD_W'(root_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
		assign take = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[i] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
			end
		end

		if (i < ROOT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= take ? (rem_in - trial) : rem_in;
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

// ===== design/triangle_quad_double_area.sv =====
// Top level: twice the area of a 2D triangle, a 3D triangle or a 3D quad.
// It accepts one face per cycle unless stalled; the square root takes one stage per result bit.
// The whole pipeline advances on one enable, held only while the output skid register is full
// and the last stage holds a finished result.
// arst_n clears all valid bits and the skid buffer and sets face_mode to 3D triangle.
`timescale 1ns / 1ps

module triangle_quad_double_area #(
	parameter int COORD_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [1:0]                              cfg_data,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz, dx, dy, dz from bit 0 up, COORD_BITS each.
	input  logic [((12*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// double_area in the low 36 bits, zero padded above.
	output logic [tqda_pkg::OUT_TDATA_W-1:0]        m_tdata
);

	localparam int CROSS_W = 2 * COORD_BITS + 3;
	localparam int MAG_W = 2 * COORD_BITS + 2;
	localparam int SUM_W = 4 * COORD_BITS + 6;
	localparam int ROOT_W = 2 * COORD_BITS + 3;
	localparam int NUM_STAGES = 4 + 3 + ROOT_W;
	localparam int XY_DELAY = 3 + ROOT_W;

	logic [1:0]                 mode_q;
	logic [NUM_STAGES-1:0]      valid_q;
	logic                       last_valid;
	logic                       pipe_en;

	logic signed [COORD_BITS-1:0] fa [tqda_pkg::AXES];
	logic signed [COORD_BITS-1:0] fb [tqda_pkg::AXES];
	logic signed [COORD_BITS-1:0] fc [tqda_pkg::AXES];
	logic signed [COORD_BITS-1:0] fd [tqda_pkg::AXES];

	logic        [MAG_W-1:0]   mag1 [tqda_pkg::AXES];
	logic        [MAG_W-1:0]   mag2 [tqda_pkg::AXES];
	logic signed [CROSS_W-1:0] xy1;
	logic signed [CROSS_W-1:0] xy_q [XY_DELAY];
	logic        [SUM_W-1:0]   sum1;
	logic        [SUM_W-1:0]   sum2;
	logic        [ROOT_W-1:0]  root1;
	logic        [ROOT_W-1:0]  root2;
	logic        [ROOT_W:0]    quad_sum;
	logic [tqda_pkg::OUT_BITS-1:0] result;

	logic [tqda_pkg::OUT_BITS-1:0] out_q;
	logic [tqda_pkg::OUT_BITS-1:0] skid_q;
	logic                          mvalid_q;
	logic                          skid_valid_q;
	logic                          push;
	logic                          pop;

	// Configuration register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tqda_pkg::MODE_TRI;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// Field unpacking.
	for (genvar k = 0; k < tqda_pkg::AXES; k++) begin : g_unpack
		assign fa[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
		assign fb[k] = s_tdata[(3+k)*COORD_BITS +: COORD_BITS];
		assign fc[k] = s_tdata[(6+k)*COORD_BITS +: COORD_BITS];
		assign fd[k] = s_tdata[(9+k)*COORD_BITS +: COORD_BITS];
	end

	// Pipeline control: every stage shifts together unless the skid register is occupied
	// and a finished result would need somewhere to go.
	assign last_valid = valid_q[NUM_STAGES-1];
	assign pipe_en = !skid_valid_q || !last_valid;
	assign s_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (pipe_en) begin
			valid_q <= {valid_q[NUM_STAGES-2:0], s_tvalid};
		end
	end

	// Triangle a,b,c and triangle c,d,a.
	tqda_cross #(.COORD_BITS(COORD_BITS)) u_cross1 (
		.clk      (clk),
		.en       (pipe_en),
		.p        (fa),
		.q        (fb),
		.t        (fc),
		.mag      (mag1),
		.cross_xy (xy1)
	);

	tqda_cross #(.COORD_BITS(COORD_BITS)) u_cross2 (
		.clk      (clk),
		.en       (pipe_en),
		.p        (fc),
		.q        (fd),
		.t        (fa),
		.mag      (mag2),
		.cross_xy ()
	);

	tqda_square #(.COORD_BITS(COORD_BITS)) u_square1 (
		.clk (clk),
		.en  (pipe_en),
		.mag (mag1),
		.sum (sum1)
	);

	tqda_square #(.COORD_BITS(COORD_BITS)) u_square2 (
		.clk (clk),
		.en  (pipe_en),
		.mag (mag2),
		.sum (sum2)
	);

	tqda_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt1 (
		.clk  (clk),
		.en   (pipe_en),
		.rad  (sum1),
		.root (root1)
	);

	tqda_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt2 (
		.clk  (clk),
		.en   (pipe_en),
		.rad  (sum2),
		.root (root2)
	);

	// The signed 2D cross product rides alongside the square and root stages.
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			xy_q[0] <= xy1;
			for (int i = 1; i < XY_DELAY; i++) begin
				xy_q[i] <= xy_q[i-1];
			end
		end
	end

	assign quad_sum = (ROOT_W + 1)'(root1) + (ROOT_W + 1)'(root2);

	always_comb begin
		if (mode_q == tqda_pkg::MODE_2D) begin
			result = tqda_pkg::OUT_BITS'(xy_q[XY_DELAY-1]);
		end else if ((mode_q & tqda_pkg::QUAD_FLAG) != 2'b00) begin
			result = tqda_pkg::OUT_BITS'(quad_sum);
		end else begin
			result = tqda_pkg::OUT_BITS'(root1);
		end
	end

	// Output register with a skid entry behind it.
	assign push = last_valid && pipe_en;
	assign pop = mvalid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (mvalid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				mvalid_q <= 1'b1;
			end
		end else if (pop) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (mvalid_q && !pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = tqda_pkg::OUT_TDATA_W'(out_q);

	// A waiting skid entry always has an occupied output register in front of it.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> mvalid_q)
		else $error("skid entry held while output register is empty");

	// A stalled pipeline keeps all of its valid bits.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(valid_q))
		else $error("pipeline valid bits moved during a stall");

	// A finished result leaving the pipeline lands in the output register.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> mvalid_q)
		else $error("result left the pipeline but no output is valid");

	// No new face enters while a result is blocked behind a full skid entry.
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && last_valid) |-> !s_tready)
		else $error("input accepted while the output path is full");

endmodule
